// File: src/sdbm_tbl_pkg.sv
`timescale 1ns / 1ps

package sdbm_tbl_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int HASH_W          = 32;
	localparam int SLOT_W          = 10;
	localparam int COUNT_W         = 11;
	localparam int RATING_W        = 3;
	localparam int DATA_W          = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [7:0]          key_byte;
		logic [RATING_W-1:0] item_rating;
		logic [DATA_W-1:0]   item_data;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_index;
		logic [RATING_W-1:0] read_rating;
		logic [DATA_W-1:0]   read_data;
		logic [COUNT_W-1:0]  element_count;
	} out_item_t;

	// finished key waiting for the table side
	typedef struct packed {
		logic                is_write;
		logic [HASH_W-1:0]   hash;
		logic [RATING_W-1:0] rating;
		logic [DATA_W-1:0]   data;
	} op_t;

	typedef struct packed {
		logic [RATING_W-1:0] rating;
		logic [DATA_W-1:0]   data;
	} slot_t;

	function automatic logic [HASH_W-1:0] sdbm_fold(logic [HASH_W-1:0] h, logic [7:0] c);
		logic [HASH_W-1:0] cx;
		cx = {{(HASH_W-8){c[7]}}, c};
		return cx + (h << 6) + (h << 16) - h;
	endfunction

endpackage

// File: src/sdbm_tbl_front.sv
`timescale 1ns / 1ps

module sdbm_tbl_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sdbm_tbl_pkg::in_item_t in_data,
	input  logic                   clearing,
	output logic                   push_valid,
	input  logic                   push_ready,
	output sdbm_tbl_pkg::op_t      push_data
);
	import sdbm_tbl_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic              is_finish;
	logic              accept;

	always_comb begin
		case (in_data.kind)
			KIND_WRITE, KIND_READ: is_finish = 1'b1;
			default:               is_finish = 1'b0;
		endcase
	end

	assign in_ready   = !clearing && push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && !clearing && is_finish;

	assign push_data.is_write = (in_data.kind == KIND_WRITE);
	assign push_data.hash     = hash_q;
	assign push_data.rating   = in_data.item_rating;
	assign push_data.data     = in_data.item_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			case (in_data.kind)
				KIND_KEY:              hash_q <= sdbm_fold(hash_q, in_data.key_byte);
				KIND_WRITE, KIND_READ: hash_q <= '0;
				default:               hash_q <= hash_q;
			endcase
		end
	end

	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> hash_q == '0)
		else $error("running hash not cleared after finishing beat");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(push_valid && push_ready) && !in_ready)
		else $error("beat taken during table clear");

endmodule

// File: src/sdbm_tbl_queue.sv
`timescale 1ns / 1ps

module sdbm_tbl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  sdbm_tbl_pkg::op_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output sdbm_tbl_pkg::op_t pop_data
);
	import sdbm_tbl_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	op_t            entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != QCW'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/sdbm_tbl_back.sv
`timescale 1ns / 1ps

module sdbm_tbl_back #(
	parameter int TABLE_DEPTH = sdbm_tbl_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [sdbm_tbl_pkg::RATING_W-1:0]     empty_mark,
	output logic                                  clearing,
	input  logic                                  pop_valid,
	output logic                                  pop_ready,
	input  sdbm_tbl_pkg::op_t                     pop_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output sdbm_tbl_pkg::out_item_t               out_data
);
	import sdbm_tbl_pkg::*;

	localparam int  IDX_W      = $clog2(TABLE_DEPTH);
	localparam int  RW         = IDX_W + 1;
	localparam bit  IS_POW2    = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam int  DIV_BITS   = 4;
	localparam int  DIV_CYCLES = HASH_W / DIV_BITS;
	localparam int  STEP_W     = $clog2(DIV_CYCLES);
	localparam logic [RW-1:0]      DepthR   = RW'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0]   LastIdx  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [COUNT_W-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_RESP
	} state_t;

	state_t             state_q;
	op_t                cur_q;
	logic [HASH_W-1:0]  div_q;
	logic [RW-1:0]      rem_q;
	logic [RW-1:0]      rem_next;
	logic [STEP_W-1:0]  step_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   clr_q;
	logic               clearing_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               out_valid_q;
	out_item_t          out_data_q;

	slot_t              mem [TABLE_DEPTH];
	slot_t              rd_slot_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	slot_t              mem_wdata;
	logic               mem_re;
	logic               resp_fire;

	assign clearing  = clearing_q;
	assign pop_ready = (state_q == ST_IDLE) && !clearing_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign resp_fire = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	assign mem_re    = (state_q == ST_READ);

	// restoring remainder, DIV_BITS hash bits per ST_DIV step, msb first
	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] t;
		r = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r[RW-2:0], div_q[HASH_W-1-i]};
			if (t >= DepthR) begin
				t = t - DepthR;
			end
			r = t;
		end
		rem_next = r;
	end

	always_comb begin
		count_next = count_q;
		if (cur_q.is_write && rd_slot_q.rating == empty_mark && count_q != CountMax) begin
			count_next = count_q + 1'b1;
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = resp_fire && cur_q.is_write;
			mem_waddr = idx_q;
			mem_wdata = '{rating: cur_q.rating, data: cur_q.data};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_slot_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == LastIdx) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			step_q      <= '0;
			cur_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			out_data_q  <= '0;
		end else begin
			if (resp_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_ready) begin
						cur_q  <= pop_data;
						div_q  <= pop_data.hash;
						rem_q  <= '0;
						step_q <= '0;
						idx_q  <= pop_data.hash[IDX_W-1:0];
						state_q <= IS_POW2 ? ST_READ : ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					div_q  <= div_q << DIV_BITS;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
						idx_q   <= rem_next[IDX_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (resp_fire) begin
						count_q                  <= count_next;
						out_data_q.slot_index    <= SLOT_W'(idx_q);
						out_data_q.read_rating   <= rd_slot_q.rating;
						out_data_q.read_data     <= rd_slot_q.data;
						out_data_q.element_count <= count_next;
						state_q                  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> state_q == ST_IDLE && !out_valid_q)
		else $error("table busy during clear pass");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("element count went down");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP |-> idx_q <= LastIdx)
		else $error("slot index beyond table depth");

endmodule

// File: src/sdbm_hashed_direct_table_unit.sv
`timescale 1ns / 1ps
// key byte beats: one per cycle while in_ready is high (no clear, queue not full),
// folded into the running hash as they are taken
// finishing beat: slot is the hash mod TABLE_DEPTH, the low hash bits for a power-of-two
// depth, else found in 8 remainder steps, 4 hash bits each; table side works on one
// finishing beat at a time, one read port; a 2-entry queue holds finished keys meanwhile
// reset: hash, count and mark cleared; table then cleared slot by slot, input held off
module sdbm_hashed_direct_table_unit #(
	parameter int TABLE_DEPTH = sdbm_tbl_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sdbm_tbl_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sdbm_tbl_pkg::out_item_t           out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sdbm_tbl_pkg::RATING_W-1:0] cfg_data
);
	import sdbm_tbl_pkg::*;

	logic [RATING_W-1:0] mark_q;
	logic                clearing;
	logic                push_valid;
	logic                push_ready;
	op_t                 push_data;
	logic                pop_valid;
	logic                pop_ready;
	op_t                 pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mark_q <= cfg_data;
		end
	end

	sdbm_tbl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sdbm_tbl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sdbm_tbl_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty_mark (mark_q),
		.clearing   (clearing),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: tb/sv/sdbm_hashed_direct_table_unit_tb.sv
`timescale 1ns / 1ps

module sdbm_hashed_direct_table_unit_tb;
	import sdbm_tbl_pkg::*;

	localparam int         TBL_DEPTH  = TABLE_DEPTH_DEF;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int         POOL_KEYS  = 24;
	localparam int         POOL_LEN   = 8;

	// mirror of the table: running hash, slot contents, fill count
	class hash_table_tracker;
		logic [HASH_W-1:0]   hash;
		logic [RATING_W-1:0] mark;
		logic [RATING_W-1:0] rating_mem [TBL_DEPTH];
		logic [DATA_W-1:0]   data_mem [TBL_DEPTH];
		logic [COUNT_W-1:0]  filled;
		out_item_t           lookups [$];
		int                  errors;

		function new();
			hash = '0;
			mark = '0;
			filled = '0;
			errors = 0;
			foreach (rating_mem[i]) begin
				rating_mem[i] = '0;
				data_mem[i] = '0;
			end
		endfunction

		function void take_beat(in_item_t it);
			out_item_t          want;
			logic [HASH_W-1:0]  slot;
			case (it.kind)
				KIND_KEY: begin
					// 65599 = 2^6 + 2^16 - 1, wraps at 32 bits
					hash = hash * 32'd65599 + {{(HASH_W-8){it.key_byte[7]}}, it.key_byte};
				end
				KIND_WRITE, KIND_READ: begin
					slot = hash % TBL_DEPTH;
					hash = '0;
					want.slot_index = slot[SLOT_W-1:0];
					want.read_rating = rating_mem[slot];
					want.read_data = data_mem[slot];
					if (it.kind == KIND_WRITE) begin
						if (rating_mem[slot] == mark && filled != {COUNT_W{1'b1}})
							filled = filled + 1'b1;
						rating_mem[slot] = it.item_rating;
						data_mem[slot] = it.item_data;
					end
					want.element_count = filled;
					lookups.push_back(want);
				end
				default: ;
			endcase
		endfunction

		function void diff(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, what, want, got);
			end
		endfunction

		function void match_lookup(out_item_t got);
			out_item_t want;
			if (lookups.size() == 0) begin
				errors++;
				$display("%0t: result expected none got slot %h rating %h data %h count %h",
					$time, got.slot_index, got.read_rating, got.read_data,
					got.element_count);
				return;
			end
			want = lookups.pop_front();
			diff("slot_index", 32'(want.slot_index), 32'(got.slot_index));
			diff("read_rating", 32'(want.read_rating), 32'(got.read_rating));
			diff("read_data", want.read_data, got.read_data);
			diff("element_count", 32'(want.element_count), 32'(got.element_count));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RATING_W-1:0] cfg_data = '0;

	hash_table_tracker tracker;
	bit                calm = 1'b0;
	bit                hold_req = 1'b0;
	int                beats_sent = 0;
	logic [7:0]        pool_bytes [POOL_KEYS][POOL_LEN];
	int                pool_len [POOL_KEYS];

	sdbm_hashed_direct_table_unit #(.TABLE_DEPTH(TBL_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// result side: checks every beat taken, stalls in bursts or one long hold
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.match_lookup(out_data);
			if (stall > 0) begin
				stall--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall = 80;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 3);
			end
			out_ready <= (stall == 0);
		end
	end

	function automatic in_item_t pack_beat(logic [1:0] k, logic [7:0] b,
			logic [RATING_W-1:0] r, logic [DATA_W-1:0] d);
		in_item_t it;
		it.kind = k;
		it.key_byte = b;
		it.item_rating = r;
		it.item_data = d;
		return it;
	endfunction

	task automatic offer(input in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		tracker.take_beat(it);
		if (it.kind != KIND_SPARE)
			beats_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic offer_byte(input logic [7:0] b);
		offer(pack_beat(KIND_KEY, b, 3'($urandom_range(0, 7)), $urandom));
	endtask

	task automatic offer_pool_key(input int n);
		for (int i = 0; i < pool_len[n]; i++)
			offer_byte(pool_bytes[n][i]);
	endtask

	task automatic offer_finish(input bit is_write);
		logic [RATING_W-1:0] r;
		logic [DATA_W-1:0]   d;
		r = ($urandom_range(0, 3) == 0) ? tracker.mark : 3'($urandom_range(0, 7));
		d = ($urandom_range(0, 9) == 0) ? {DATA_W{1'b1}} : DATA_W'($urandom);
		offer(pack_beat(is_write ? KIND_WRITE : KIND_READ, 8'($urandom), r, d));
	endtask

	task automatic set_mark(input logic [RATING_W-1:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		tracker.mark = m;
		cfg_valid <= 1'b0;
	endtask

	// wait out every lookup plus the hash pipeline before touching the mark
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.lookups.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic directed_run();
		// no key at all lands on slot 0, still at its cleared contents
		offer(pack_beat(KIND_READ, 8'h00, 3'd0, 32'h0));
		offer(pack_beat(KIND_SPARE, 8'hff, 3'd7, 32'hffff_ffff));
		offer_byte(8'h01);
		offer_byte(8'hff);
		offer_byte(8'h80);
		offer_byte(8'h7f);
		offer_byte(8'h00);
		offer(pack_beat(KIND_WRITE, 8'h00, 3'd7, 32'hffff_ffff));
		offer_byte(8'h01);
		offer_byte(8'hff);
		offer_byte(8'h80);
		offer_byte(8'h7f);
		offer_byte(8'h00);
		offer(pack_beat(KIND_READ, 8'hff, 3'd0, 32'h0));
		// storing the empty mark keeps the slot counting as empty
		offer_byte(8'h41);
		offer(pack_beat(KIND_WRITE, 8'h00, 3'd0, 32'h0));
		offer_byte(8'h41);
		offer(pack_beat(KIND_WRITE, 8'h00, 3'd5, 32'ha5a5_a5a5));
		offer_byte(8'h41);
		offer(pack_beat(KIND_READ, 8'h00, 3'd0, 32'h0));
		// spare kind between key bytes must not disturb the hash
		offer_byte(8'h42);
		offer(pack_beat(KIND_SPARE, 8'h43, 3'd2, 32'h1234_5678));
		offer_byte(8'h43);
		offer(pack_beat(KIND_WRITE, 8'h55, 3'd3, 32'h0f0f_0f0f));
		offer(pack_beat(KIND_WRITE, 8'haa, 3'd6, 32'h8000_0001));
	endtask

	task automatic random_run(input int n);
		int goal;
		int pick;
		goal = beats_sent + n;
		while (beats_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				if ($urandom_range(0, 9) < 6) begin
					offer_pool_key($urandom_range(0, POOL_KEYS - 1));
				end else begin
					repeat ($urandom_range(0, 8)) offer_byte(8'($urandom_range(0, 255)));
				end
				offer_finish($urandom_range(0, 1));
			end else if (pick < 90) begin
				offer(pack_beat(KIND_SPARE, 8'($urandom), 3'($urandom), $urandom));
			end else begin
				// stray bytes with no finish, they run into the next key
				repeat ($urandom_range(1, 3)) offer_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : stimulus
		tracker = new();
		foreach (pool_len[k]) begin
			pool_len[k] = $urandom_range(1, POOL_LEN);
			for (int i = 0; i < POOL_LEN; i++)
				pool_bytes[k][i] = 8'($urandom_range(1, 255));
		end
		pool_bytes[0][0] = 8'h00;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_mark(3'd0);
		directed_run();
		settle();

		set_mark(3'd7);
		random_run(250);
		settle();

		set_mark(3'd3);
		random_run(120);
		settle();
		random_run(130);
		settle();

		set_mark(3'($urandom_range(0, 7)));
		// long result hold while finishing beats keep coming
		hold_req = 1'b1;
		repeat (24) begin
			offer_pool_key($urandom_range(0, POOL_KEYS - 1));
			offer_finish($urandom_range(0, 1));
		end
		random_run(200);
		settle();

		calm = 1'b1;
		set_mark(3'd0);
		random_run(250);
		in_valid <= 1'b0;
		while (tracker.lookups.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (tracker.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
src/sdbm_tbl_pkg.sv
src/sdbm_tbl_front.sv
src/sdbm_tbl_queue.sv
src/sdbm_tbl_back.sv
src/sdbm_hashed_direct_table_unit.sv
tb/sv/sdbm_hashed_direct_table_unit_tb.sv
